// ===== rtl/msag_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ModR/M / SIB address generator.
// No dependencies; every other file imports this package.
package msag_pkg;

    localparam int unsigned GREG_COUNT = 8;
    localparam int unsigned GREG_AW    = $clog2(GREG_COUNT);
    localparam int unsigned GREG_W     = 64;
    localparam int unsigned TAIL_W     = 40;
    localparam int unsigned DISP_W     = 32;

    // ModR/M mod field codes
    localparam logic [1:0] MOD_IND = 2'd0;
    localparam logic [1:0] MOD_D8  = 2'd1;
    localparam logic [1:0] MOD_D32 = 2'd2;
    localparam logic [1:0] MOD_REG = 2'd3;

    // special rm / SIB field codes
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_ABS    = 3'd5;
    localparam logic [2:0] IDX_NONE  = 3'd4;
    localparam logic [2:0] BASE_NONE = 3'd5;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_8    = 2'd1,
        DISP_32   = 2'd2
    } t_disp_kind;

    typedef struct packed {
        logic                 mode;
        logic [7:0]           modrm;
        logic [TAIL_W-1:0]    tail_bytes;
        logic [GREG_AW-1:0]   write_index;
        logic [GREG_W-1:0]    write_value;
    } t_req;

    typedef struct packed {
        logic [2:0]           reg_field;
        logic [2:0]           rm_field;
        logic                 is_memory;
        logic                 has_sib;
        logic [1:0]           disp_kind;
        logic signed [DISP_W-1:0] displacement;
        logic [2:0]           length;
        logic [GREG_W-1:0]    effective_address;
    } t_rsp;

    // registered register-file read data for one decode request
    typedef struct packed {
        logic [GREG_W-1:0]    base_val;
        logic [GREG_W-1:0]    index_val;
    } t_operands;

endpackage

// ===== rtl/msag_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response traffic.
// Depends on msag_pkg for the payload structs.
interface msag_req_if;
    import msag_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msag_rsp_if;
    import msag_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/modrm_sib_address_generator.sv =====
`timescale 1ns / 1ps
// Channel     Dir  Payload  Notes
// i_req       in   t_req    mode 1 loads a register, mode 0 decodes
// o_rsp       out  t_rsp    one response per decode request, none per write
//
// When a decode request is accepted, the register file read is registered
// with the request; the address sum is then registered into the output
// once the output stage is free. One request is accepted every cycle as
// long as the output is taken. A write lands in the register file at
// acceptance, so the very next decode already sees it. Reset is synchronous
// and clears the registers to zero and both stages to empty. A stalled output
// holds its response and backs up into the decode stage, then into
// i_req.ready.
// Depends on msag_pkg, msag_if, msag_regfile and msag_ea.
module modrm_sib_address_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    msag_req_if.sink           i_req,
    msag_rsp_if.source         o_rsp
);
    import msag_pkg::*;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic              s1_ready;
    logic              s2_ready;
    logic [1:0]        in_mod;
    logic [2:0]        in_rm;
    logic              in_sib;
    logic [GREG_AW-1:0] base_sel;
    logic [GREG_AW-1:0] index_sel;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic [7:0]        r_s1_modrm;
    logic [TAIL_W-1:0] r_s1_tail;
    logic              r_out_valid;
    logic              n_out_valid;
    t_rsp              r_out_data;

    t_operands         operands;
    t_rsp              ea_rsp;

    assign s2_ready    = !r_out_valid || o_rsp.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_req.ready = s1_ready;
    assign accept      = i_req.valid && s1_ready;
    assign wr_en       = accept && i_req.data.mode;
    assign rd_en       = accept && !i_req.data.mode;

    // pick register file read addresses from the raw request bytes
    assign in_mod    = i_req.data.modrm[7:6];
    assign in_rm     = i_req.data.modrm[2:0];
    assign in_sib    = (in_mod != MOD_REG) && (in_rm == RM_SIB);
    assign base_sel  = in_sib ? i_req.data.tail_bytes[2:0] : in_rm;
    assign index_sel = i_req.data.tail_bytes[5:3];

    msag_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (i_req.data.write_index),
        .i_wr_data   (i_req.data.write_value),
        .i_rd_en     (rd_en),
        .i_base_sel  (base_sel),
        .i_index_sel (index_sel),
        .o_operands  (operands)
    );

    msag_ea u_ea (
        .i_modrm    (r_s1_modrm),
        .i_tail     (r_s1_tail),
        .i_operands (operands),
        .o_rsp      (ea_rsp)
    );

    always_comb begin
        n_s1_valid  = s1_ready ? rd_en : r_s1_valid;
        n_out_valid = s2_ready ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_modrm <= i_req.data.modrm;
            r_s1_tail  <= i_req.data.tail_bytes;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_data <= ea_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule

// ===== rtl/msag_regfile.sv =====
`timescale 1ns / 1ps
// Eight 64-bit general registers: one write port, two registered read ports.
// Depends on msag_pkg.
module msag_regfile (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [msag_pkg::GREG_AW-1:0] i_wr_addr,
    input  logic [msag_pkg::GREG_W-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [msag_pkg::GREG_AW-1:0] i_base_sel,
    input  logic [msag_pkg::GREG_AW-1:0] i_index_sel,
    output msag_pkg::t_operands          o_operands
);
    import msag_pkg::*;

    logic [GREG_W-1:0] r_greg [GREG_COUNT];
    t_operands         r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_greg <= '{default: '0};
        end else if (i_wr_en) begin
            r_greg[i_wr_addr] <= i_wr_data;
        end
    end

    // read data is held while the decode request waits downstream
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.base_val  <= r_greg[i_base_sel];
            r_rd.index_val <= r_greg[i_index_sel];
        end
    end

    assign o_operands = r_rd;

endmodule

// ===== rtl/msag_ea.sv =====
`timescale 1ns / 1ps
// Field split, displacement extraction, length and effective address sum.
// Pure combinational; depends on msag_pkg.
module msag_ea (
    input  logic [7:0]                  i_modrm,
    input  logic [msag_pkg::TAIL_W-1:0] i_tail,
    input  msag_pkg::t_operands         i_operands,
    output msag_pkg::t_rsp              o_rsp
);
    import msag_pkg::*;

    logic [1:0]        mod_f;
    logic [2:0]        reg_f;
    logic [2:0]        rm_f;
    logic              is_mem;
    logic              sib;
    logic [1:0]        scale;
    logic [2:0]        sib_idx;
    logic [2:0]        sib_base;
    logic              no_base;
    t_disp_kind        kind;
    logic [7:0]        d8;
    logic [DISP_W-1:0] d32;
    logic [DISP_W-1:0] disp;
    logic [2:0]        disp_len;
    logic [GREG_W-1:0] base_term;
    logic [GREG_W-1:0] index_term;
    logic [GREG_W-1:0] disp_term;

    always_comb begin
        mod_f    = i_modrm[7:6];
        reg_f    = i_modrm[5:3];
        rm_f     = i_modrm[2:0];
        is_mem   = (mod_f != MOD_REG);
        sib      = is_mem && (rm_f == RM_SIB);
        scale    = i_tail[7:6];
        sib_idx  = i_tail[5:3];
        sib_base = i_tail[2:0];

        no_base = (mod_f == MOD_IND) &&
                  ((sib && sib_base == BASE_NONE) || (!sib && rm_f == RM_ABS));

        case (mod_f)
            MOD_D8:  kind = DISP_8;
            MOD_D32: kind = DISP_32;
            MOD_IND: kind = no_base ? DISP_32 : DISP_NONE;
            default: kind = DISP_NONE;
        endcase

        // displacement starts after the SIB byte when one is present
        d8  = sib ? i_tail[15:8] : i_tail[7:0];
        d32 = sib ? i_tail[39:8] : i_tail[31:0];

        case (kind)
            DISP_8: begin
                disp     = {{(DISP_W-8){d8[7]}}, d8};
                disp_len = 3'd1;
            end
            DISP_32: begin
                disp     = d32;
                disp_len = 3'd4;
            end
            default: begin
                disp     = '0;
                disp_len = 3'd0;
            end
        endcase

        base_term  = (!is_mem || no_base) ? '0 : i_operands.base_val;
        index_term = (sib && sib_idx != IDX_NONE) ? (i_operands.index_val << scale) : '0;
        disp_term  = {{(GREG_W-DISP_W){disp[DISP_W-1]}}, disp};

        o_rsp.reg_field         = reg_f;
        o_rsp.rm_field          = rm_f;
        o_rsp.is_memory         = is_mem;
        o_rsp.has_sib           = sib;
        o_rsp.disp_kind         = kind;
        o_rsp.displacement      = disp;
        o_rsp.length            = 3'd1 + {2'b00, sib} + disp_len;
        o_rsp.effective_address = is_mem ? (base_term + index_term + disp_term) : '0;
    end

endmodule

// ===== rtl/msag_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the response channel of the address generator.
// Depends on msag_pkg; bound to modrm_sib_address_generator below.
module msag_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            i_ready,
    input msag_pkg::t_rsp  i_data
);
    import msag_pkg::*;

    // hold a stalled response
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("stalled response dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("response valid right after reset");

    a_reg_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_data.is_memory |-> i_data.effective_address == '0 &&
        i_data.length == 3'd1 && !i_data.has_sib && i_data.disp_kind == DISP_NONE)
        else $error("register operand with memory fields set");

    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_data.length == 3'd1 + {2'b00, i_data.has_sib} +
        ((i_data.disp_kind == DISP_8) ? 3'd1 :
         (i_data.disp_kind == DISP_32) ? 3'd4 : 3'd0))
        else $error("length disagrees with SIB and displacement");

    a_no_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data.disp_kind == DISP_NONE |-> i_data.displacement == '0)
        else $error("displacement present without a displacement kind");

endmodule

bind modrm_sib_address_generator msag_checker u_msag_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_data  (o_rsp.data)
);
